/* rtl/sot_pkg.sv */
package sot_pkg;

  // Default configuration of the table.
  localparam int MAX_SPHERES_DEF = 32;
  localparam int COORD_BITS_DEF  = 20;

  // Fixed field widths.
  localparam int RAD_W  = 19;
  localparam int TOL_W  = 16;
  localparam int STAT_W = 3;

  // Shared multiplier: one 32 by 32 product per cycle.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_CENTER_TOL = 1'b0;
  localparam logic REG_RADIUS_TOL = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOHIT    = 3'd4;

  // Tolerance registers as seen by the sequencer.
  typedef struct packed {
    logic [TOL_W-1:0] center_rel_tol;
    logic [RAD_W-1:0] radius_abs_tol;
  } sot_cfg_t;

endpackage

/* rtl/sot_ram.sv */
module sot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/sot_mul.sv */
module sot_mul (
  input  logic                      clk,
  input  logic [sot_pkg::MUL_W-1:0] a,
  input  logic [sot_pkg::MUL_W-1:0] b,
  output logic [sot_pkg::PROD_W-1:0] prod
);

  import sot_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // The product is registered before anything uses it.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

/* rtl/sot_cfg.sv */
module sot_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sot_pkg::ADDR_W-1:0] paddr,
  input  logic [sot_pkg::DATA_W-1:0] pwdata,
  output logic [sot_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sot_pkg::sot_cfg_t          cfg
);

  import sot_pkg::*;

  logic [TOL_W-1:0] center_rel_tol_r, center_rel_tol_nxt;
  logic [RAD_W-1:0] radius_abs_tol_r, radius_abs_tol_nxt;
  logic             wr_req;

  assign pready = 1'b1;
  assign wr_req = psel & penable & pwrite;

  // Write decode; the low address bits select nothing.
  always_comb begin
    center_rel_tol_nxt = center_rel_tol_r;
    radius_abs_tol_nxt = radius_abs_tol_r;
    if (wr_req) begin
      unique case (paddr[2])
        REG_CENTER_TOL: center_rel_tol_nxt = pwdata[TOL_W-1:0];
        REG_RADIUS_TOL: radius_abs_tol_nxt = pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_rel_tol_r <= TOL_W'(1);
      radius_abs_tol_r <= RAD_W'(1);
    end else begin
      center_rel_tol_r <= center_rel_tol_nxt;
      radius_abs_tol_r <= radius_abs_tol_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (paddr[2])
      REG_CENTER_TOL: prdata = DATA_W'(center_rel_tol_r);
      REG_RADIUS_TOL: prdata = DATA_W'(radius_abs_tol_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.center_rel_tol = center_rel_tol_r;
  assign cfg.radius_abs_tol = radius_abs_tol_r;

endmodule

/* rtl/sphere_obstacle_table_core.sv */
// Channel  Ports                                         Direction  Moves
// input    in_valid, in_stall, in_req_type .. in_extent  in         one request
// output   out_valid, out_stall, out_status .. out_last  out        one result
// config   psel, penable, pwrite, paddr, pwdata, prdata  in/out     register access
//
// A request is taken only in the idle state; an insert and a query each test the n stored spheres
// one after another, and a result may also wait on out_stall. The sequencer works through the
// single shared multiplier: every square and every partial product of the tolerance test is one
// pass through it, and each entry needs one RAM read.
// Reset (rst_n, synchronous) empties the table and sets both tolerances to one.
// The result register lets a new request start while a result still waits on out_stall.
module sphere_obstacle_table_core #(
  parameter int MAX_SPHERES = sot_pkg::MAX_SPHERES_DEF,
  parameter int COORD_BITS  = sot_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  input  logic [sot_pkg::RAD_W-1:0]     in_extent,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sot_pkg::STAT_W-1:0]    out_status,
  output logic signed [COORD_BITS-1:0]  out_hit_x,
  output logic signed [COORD_BITS-1:0]  out_hit_y,
  output logic signed [COORD_BITS-1:0]  out_hit_z,
  output logic [sot_pkg::RAD_W-1:0]     out_hit_radius,
  output logic                          out_last,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sot_pkg::ADDR_W-1:0]    paddr,
  input  logic [sot_pkg::DATA_W-1:0]    pwdata,
  output logic [sot_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import sot_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int IDX_W  = MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
  localparam int ENT_W  = 3 * C + RAD_W;
  localparam int NORM_W = 2 * C;
  localparam int D2_W   = 2 * C + 2;
  localparam int TOL_SH = 2 * TOL_W;
  localparam int LHS_W  = D2_W + TOL_SH;
  localparam int RHS_W  = NORM_W + 2 * TOL_W;
  localparam int LIM_W  = 2 * (RAD_W + 1);
  localparam int QCMP_W = D2_W > LIM_W ? D2_W : LIM_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Steps of the insert preparation.
  localparam logic [3:0] K_TOL = 4'd0;
  localparam logic [3:0] K_NPX = 4'd1;
  localparam logic [3:0] K_NPY = 4'd2;
  localparam logic [3:0] K_NPZ = 4'd3;
  localparam logic [3:0] K_NPS = 4'd4;
  // Steps shared by both entry tests.
  localparam logic [3:0] K_DX  = 4'd0;
  localparam logic [3:0] K_DY  = 4'd1;
  localparam logic [3:0] K_DZ  = 4'd2;
  // Steps of the insert match test.
  localparam logic [3:0] K_CX   = 4'd3;
  localparam logic [3:0] K_CY   = 4'd4;
  localparam logic [3:0] K_CZ   = 4'd5;
  localparam logic [3:0] K_NC   = 4'd6;
  localparam logic [3:0] K_RLO  = 4'd7;
  localparam logic [3:0] K_RHI  = 4'd8;
  localparam logic [3:0] K_RSUM = 4'd9;
  localparam logic [3:0] K_CMP  = 4'd10;
  // Steps of the query range test.
  localparam logic [3:0] K_SS   = 4'd3;
  localparam logic [3:0] K_LIM  = 4'd4;
  localparam logic [3:0] K_QCMP = 4'd5;

  // Magnitude of a - b for two signed coordinates.
  function automatic logic [C-1:0] absdiff(input logic [C-1:0] a, input logic [C-1:0] b);
    logic [C:0] d;
    d = {a[C-1], a} - {b[C-1], b};
    if (d[C]) begin
      d = (C + 1)'(0) - d;
    end
    return d[C-1:0];
  endfunction

  sot_cfg_t cfg;

  logic [2:0]        state_r, state_nxt;
  logic [3:0]        st_r, st_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              req_r, req_nxt;
  logic [C-1:0]      px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [RAD_W-1:0]  ext_r, ext_nxt;
  logic [TOL_SH-1:0] tol2_r, tol2_nxt;
  logic [NORM_W-1:0] np_r, np_nxt, nc_r, nc_nxt;
  logic [D2_W-1:0]   acc_r, acc_nxt;
  logic [RHS_W-1:0]  rhs_r, rhs_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [STAT_W-1:0] fin_status_r, fin_status_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [C-1:0]      pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt, pend_z_r, pend_z_nxt;
  logic [RAD_W-1:0]  pend_rad_r, pend_rad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [C-1:0]      out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic [RAD_W-1:0]  out_rad_r, out_rad_nxt;
  logic              out_last_r, out_last_nxt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              wr_en;
  logic [ENT_W-1:0]  wr_data, rd_data;
  logic [C-1:0]      ent_x, ent_y, ent_z;
  logic [RAD_W-1:0]  ent_rad, rad_diff;
  logic [RAD_W:0]    rad_sum;
  logic [NORM_W-1:0] min_norm;
  logic [PROD_W-1:0] min_pad;
  logic              out_free, last_entry, do_commit, center_ok, range_hit;

  sot_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sot_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sot_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SPHERES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(cnt_r)),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Fields of the entry under test and of a new entry.
  assign ent_x   = rd_data[ENT_W-1 -: C];
  assign ent_y   = rd_data[ENT_W-1-C -: C];
  assign ent_z   = rd_data[RAD_W +: C];
  assign ent_rad = rd_data[RAD_W-1:0];
  assign wr_data = {px_r, py_r, pz_r, ext_r};

  // Small helpers beside the multiplier.
  assign rad_diff   = (ext_r > ent_rad) ? (ext_r - ent_rad) : (ent_rad - ext_r);
  assign rad_sum    = {1'b0, ext_r} + {1'b0, ent_rad};
  assign min_norm   = (np_r < nc_r) ? np_r : nc_r;
  assign min_pad    = PROD_W'(min_norm);
  assign center_ok  = {acc_r, {TOL_SH{1'b0}}} <= LHS_W'(rhs_r);
  assign range_hit  = QCMP_W'(acc_r) < QCMP_W'(lim_r);
  assign last_entry = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = state_r != S_IDLE;

  // Sequencer: chooses the multiplier operands and collects each product from the multiplier's output register.
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    req_nxt        = req_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    ext_nxt        = ext_r;
    tol2_nxt       = tol2_r;
    np_nxt         = np_r;
    nc_nxt         = nc_r;
    acc_nxt        = acc_r;
    rhs_nxt        = rhs_r;
    lim_nxt        = lim_r;
    fin_status_nxt = fin_status_r;
    pend_v_nxt     = pend_v_r;
    pend_x_nxt     = pend_x_r;
    pend_y_nxt     = pend_y_r;
    pend_z_nxt     = pend_z_r;
    pend_rad_nxt   = pend_rad_r;
    out_valid_nxt  = out_stall ? out_valid_r : 1'b0;
    out_status_nxt = out_status_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_z_nxt      = out_z_r;
    out_rad_nxt    = out_rad_r;
    out_last_nxt   = out_last_r;
    mul_a          = '0;
    mul_b          = '0;
    wr_en          = 1'b0;
    do_commit      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          px_nxt     = in_pos_x;
          py_nxt     = in_pos_y;
          pz_nxt     = in_pos_z;
          ext_nxt    = in_extent;
          st_nxt     = '0;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          if (!in_req_type) begin
            state_nxt = S_PRE;
          end else if (cnt_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end

      // Insert only: square of the tolerance and norm of the new center.
      S_PRE: begin
        st_nxt = st_r + 4'd1;
        case (st_r)
          K_TOL: begin
            mul_a = MUL_W'(cfg.center_rel_tol);
            mul_b = MUL_W'(cfg.center_rel_tol);
          end
          K_NPX: begin
            mul_a    = MUL_W'(absdiff(px_r, '0));
            mul_b    = MUL_W'(absdiff(px_r, '0));
            tol2_nxt = TOL_SH'(prod);
          end
          K_NPY: begin
            mul_a  = MUL_W'(absdiff(py_r, '0));
            mul_b  = MUL_W'(absdiff(py_r, '0));
            np_nxt = NORM_W'(prod);
          end
          K_NPZ: begin
            mul_a  = MUL_W'(absdiff(pz_r, '0));
            mul_b  = MUL_W'(absdiff(pz_r, '0));
            np_nxt = np_r + NORM_W'(prod);
          end
          K_NPS: begin
            np_nxt = np_r + NORM_W'(prod);
            st_nxt = '0;
            if (cnt_r == '0) begin
              do_commit = 1'b1;
            end else begin
              state_nxt = S_LOAD;
            end
          end
          default: ;
        endcase
      end

      // The RAM read of the entry lands during this cycle.
      S_LOAD: begin
        st_nxt    = '0;
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        st_nxt = st_r + 4'd1;
        if (!req_r) begin
          // Match test of the new sphere against one stored entry.
          case (st_r)
            K_DX: begin
              mul_a = MUL_W'(absdiff(px_r, ent_x));
              mul_b = MUL_W'(absdiff(px_r, ent_x));
            end
            K_DY: begin
              mul_a   = MUL_W'(absdiff(py_r, ent_y));
              mul_b   = MUL_W'(absdiff(py_r, ent_y));
              acc_nxt = D2_W'(prod);
            end
            K_DZ: begin
              mul_a   = MUL_W'(absdiff(pz_r, ent_z));
              mul_b   = MUL_W'(absdiff(pz_r, ent_z));
              acc_nxt = acc_r + D2_W'(prod);
            end
            K_CX: begin
              mul_a   = MUL_W'(absdiff(ent_x, '0));
              mul_b   = MUL_W'(absdiff(ent_x, '0));
              acc_nxt = acc_r + D2_W'(prod);
            end
            K_CY: begin
              mul_a  = MUL_W'(absdiff(ent_y, '0));
              mul_b  = MUL_W'(absdiff(ent_y, '0));
              nc_nxt = NORM_W'(prod);
            end
            K_CZ: begin
              mul_a  = MUL_W'(absdiff(ent_z, '0));
              mul_b  = MUL_W'(absdiff(ent_z, '0));
              nc_nxt = nc_r + NORM_W'(prod);
            end
            K_NC: begin
              nc_nxt = nc_r + NORM_W'(prod);
            end
            K_RLO: begin
              mul_a = MUL_W'(tol2_r);
              mul_b = min_pad[MUL_W-1:0];
            end
            K_RHI: begin
              mul_a   = MUL_W'(tol2_r);
              mul_b   = min_pad[PROD_W-1:MUL_W];
              rhs_nxt = RHS_W'(prod);
            end
            K_RSUM: begin
              rhs_nxt = rhs_r + RHS_W'({prod, {MUL_W{1'b0}}});
            end
            K_CMP: begin
              st_nxt = '0;
              if (center_ok && (rad_diff < cfg.radius_abs_tol)) begin
                fin_status_nxt = ST_DUP;
                state_nxt      = S_FIN;
              end else if (last_entry) begin
                do_commit = 1'b1;
              end else begin
                idx_nxt   = idx_r + IDX_W'(1);
                state_nxt = S_LOAD;
              end
            end
            default: ;
          endcase
        end else begin
          // Range test of the query against one stored entry.
          case (st_r)
            K_DX: begin
              mul_a = MUL_W'(absdiff(px_r, ent_x));
              mul_b = MUL_W'(absdiff(px_r, ent_x));
            end
            K_DY: begin
              mul_a   = MUL_W'(absdiff(py_r, ent_y));
              mul_b   = MUL_W'(absdiff(py_r, ent_y));
              acc_nxt = D2_W'(prod);
            end
            K_DZ: begin
              mul_a   = MUL_W'(absdiff(pz_r, ent_z));
              mul_b   = MUL_W'(absdiff(pz_r, ent_z));
              acc_nxt = acc_r + D2_W'(prod);
            end
            K_SS: begin
              mul_a   = MUL_W'(rad_sum);
              mul_b   = MUL_W'(rad_sum);
              acc_nxt = acc_r + D2_W'(prod);
            end
            K_LIM: begin
              lim_nxt = LIM_W'(prod);
            end
            K_QCMP: begin
              if (range_hit && pend_v_r && !out_free) begin
                // The earlier hit cannot leave yet: hold this step.
                st_nxt = st_r;
              end else begin
                st_nxt = '0;
                // A new hit releases the one held back, which is not the last.
                if (range_hit && pend_v_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_HIT;
                  out_x_nxt      = pend_x_r;
                  out_y_nxt      = pend_y_r;
                  out_z_nxt      = pend_z_r;
                  out_rad_nxt    = pend_rad_r;
                  out_last_nxt   = 1'b0;
                end
                if (range_hit) begin
                  pend_v_nxt   = 1'b1;
                  pend_x_nxt   = ent_x;
                  pend_y_nxt   = ent_y;
                  pend_z_nxt   = ent_z;
                  pend_rad_nxt = ent_rad;
                end
                if (last_entry) begin
                  state_nxt = S_FIN;
                end else begin
                  idx_nxt   = idx_r + IDX_W'(1);
                  state_nxt = S_LOAD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Final result of the request.
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (req_r && pend_v_r) begin
            out_status_nxt = ST_HIT;
            out_x_nxt      = pend_x_r;
            out_y_nxt      = pend_y_r;
            out_z_nxt      = pend_z_r;
            out_rad_nxt    = pend_rad_r;
          end else begin
            out_status_nxt = req_r ? ST_NOHIT : fin_status_r;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_z_nxt      = '0;
            out_rad_nxt    = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // No stored sphere matched: store the new one unless the table is full.
    if (do_commit) begin
      state_nxt = S_FIN;
      if (cnt_r == CNT_W'(MAX_SPHERES)) begin
        fin_status_nxt = ST_FULL;
      end else begin
        wr_en          = 1'b1;
        cnt_nxt        = cnt_r + CNT_W'(1);
        fin_status_nxt = ST_INSERTED;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk) begin
    st_r         <= st_nxt;
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    pz_r         <= pz_nxt;
    ext_r        <= ext_nxt;
    tol2_r       <= tol2_nxt;
    np_r         <= np_nxt;
    nc_r         <= nc_nxt;
    acc_r        <= acc_nxt;
    rhs_r        <= rhs_nxt;
    lim_r        <= lim_nxt;
    fin_status_r <= fin_status_nxt;
    pend_x_r     <= pend_x_nxt;
    pend_y_r     <= pend_y_nxt;
    pend_z_r     <= pend_z_nxt;
    pend_rad_r   <= pend_rad_nxt;
    out_status_r <= out_status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_z_r      <= out_z_nxt;
    out_rad_r    <= out_rad_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hit_x      = out_x_r;
  assign out_hit_y      = out_y_r;
  assign out_hit_z      = out_z_r;
  assign out_hit_radius = out_rad_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  // The sphere count never passes the table size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SPHERES))
    else $error("sphere count beyond table size");

  // A table write only happens into a free slot.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < CNT_W'(MAX_SPHERES)))
    else $error("table write while full");

  // Only a query hit can be followed by more results.
  a_not_last_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == ST_HIT))
    else $error("non-final result that is not a hit");

  // A taken request always leaves the idle state.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request taken but sequencer stayed idle");
`endif

endmodule

/* sim/tb_sphere_obstacle_table_core.sv */
module tb_sphere_obstacle_table_core;
  import sot_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int TABLE_DEPTH = MAX_SPHERES_DEF;
  localparam int CMAX        = 2 ** (CW - 1) - 1;
  localparam int CMIN        = -(2 ** (CW - 1));
  localparam int RMAX        = 2 ** RAD_W - 1;
  localparam int PHASE_REQS  = 65;
  localparam int MAX_RUN     = 16;
  localparam int DRAIN_CYCLES = 400;

  // Request kinds on in_req_type.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef longint unsigned u64_t;
  typedef logic [127:0] u128_t;

  typedef struct {
    logic             req_type;
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    z;
    logic [RAD_W-1:0] ext;
  } sphere_request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
    logic [CW-1:0]     z;
    logic [RAD_W-1:0]  radius;
    logic              last;
  } sphere_result_t;

  // Shadow of the sphere table: predicts the results of each request and
  // matches them against what the block streams out.
  class obstacle_table_tracker;
    logic signed [CW-1:0] cx[TABLE_DEPTH];
    logic signed [CW-1:0] cy[TABLE_DEPTH];
    logic signed [CW-1:0] cz[TABLE_DEPTH];
    logic [RAD_W-1:0]     r[TABLE_DEPTH];
    int unsigned          count;
    logic [TOL_W-1:0]     center_tol;
    logic [RAD_W-1:0]     radius_tol;
    sphere_result_t       expected_results[$];
    int unsigned          status_count[8];
    int unsigned          inserts, queries, checked, failures;

    function new();
      count = 0;
      center_tol = TOL_W'(1);
      radius_tol = RAD_W'(1);
      inserts = 0;
      queries = 0;
      checked = 0;
      failures = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_tol(logic reg_sel, logic [DATA_W-1:0] value);
      if (reg_sel == REG_CENTER_TOL) center_tol = value[TOL_W-1:0];
      else radius_tol = value[RAD_W-1:0];
    endfunction

    function logic [DATA_W-1:0] tol_value(logic reg_sel);
      return (reg_sel == REG_CENTER_TOL) ? DATA_W'(center_tol) : DATA_W'(radius_tol);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    // Only the first ten failures are printed.
    function bit count_failure();
      failures++;
      return failures <= 10;
    endfunction

    function u64_t dist_sq(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                           logic signed [CW-1:0] az, logic signed [CW-1:0] bx,
                           logic signed [CW-1:0] by, logic signed [CW-1:0] bz);
      longint dx, dy, dz;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      dz = longint'(az) - longint'(bz);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function void push_result(logic [STAT_W-1:0] st, int idx, bit hit, bit last);
      sphere_result_t res;
      res.status = st;
      res.x      = hit ? cx[idx] : '0;
      res.y      = hit ? cy[idx] : '0;
      res.z      = hit ? cz[idx] : '0;
      res.radius = hit ? r[idx] : '0;
      res.last   = last;
      expected_results.insert(expected_results.size(), res);
      status_count[st]++;
    endfunction

    function void take_request(sphere_request_t rq);
      logic signed [CW-1:0] px, py, pz;
      u64_t  tol2, np, nc, d2, a, b, rd, s;
      u128_t lhs, rhs;
      bit    dup;
      int    hits;
      px = $signed(rq.x);
      py = $signed(rq.y);
      pz = $signed(rq.z);
      dup = 0;
      hits = 0;
      if (rq.req_type == REQ_INSERT) begin
        inserts++;
        // Match test: squared center distance against the scaled smaller norm,
        // and an absolute radius difference. It runs before the full check.
        tol2 = u64_t'(center_tol) * u64_t'(center_tol);
        np = dist_sq(px, py, pz, '0, '0, '0);
        for (int i = 0; i < count && !dup; i++) begin
          d2 = dist_sq(px, py, pz, cx[i], cy[i], cz[i]);
          nc = dist_sq(cx[i], cy[i], cz[i], '0, '0, '0);
          lhs = u128_t'(d2) << 32;
          rhs = u128_t'(tol2) * u128_t'((np < nc) ? np : nc);
          a = rq.ext;
          b = r[i];
          rd = (a > b) ? a - b : b - a;
          if (lhs <= rhs && rd < radius_tol) dup = 1;
        end
        if (dup) begin
          push_result(ST_DUP, 0, 1'b0, 1'b1);
        end else if (count >= TABLE_DEPTH) begin
          push_result(ST_FULL, 0, 1'b0, 1'b1);
        end else begin
          cx[count] = px;
          cy[count] = py;
          cz[count] = pz;
          r[count]  = rq.ext;
          count++;
          push_result(ST_INSERTED, 0, 1'b0, 1'b1);
        end
      end else begin
        queries++;
        // Every stored sphere strictly inside range plus its radius is a hit.
        for (int i = 0; i < count; i++) begin
          d2 = dist_sq(px, py, pz, cx[i], cy[i], cz[i]);
          s = u64_t'(rq.ext) + u64_t'(r[i]);
          if (d2 < s * s) begin
            push_result(ST_HIT, i, 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) push_result(ST_NOHIT, 0, 1'b0, 1'b1);
        else expected_results[expected_results.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(sphere_result_t got);
      sphere_result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        if (count_failure())
          $display("unexpected result: status %0d x %0d y %0d z %0d radius %0d last %0d",
                   got.status, $signed(got.x), $signed(got.y), $signed(got.z),
                   got.radius, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.radius !== want.radius || got.last !== want.last) begin
        if (count_failure()) begin
          $display("result mismatch: expected status %0d x %0d y %0d z %0d radius %0d last %0d",
                   want.status, $signed(want.x), $signed(want.y), $signed(want.z),
                   want.radius, want.last);
          $display("                 actual   status %0d x %0d y %0d z %0d radius %0d last %0d",
                   got.status, $signed(got.x), $signed(got.y), $signed(got.z),
                   got.radius, got.last);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_INSERT;
  logic signed [CW-1:0] in_pos_x = '0;
  logic signed [CW-1:0] in_pos_y = '0;
  logic signed [CW-1:0] in_pos_z = '0;
  logic [RAD_W-1:0]     in_extent = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic signed [CW-1:0] out_hit_x;
  logic signed [CW-1:0] out_hit_y;
  logic signed [CW-1:0] out_hit_z;
  logic [RAD_W-1:0]     out_hit_radius;
  logic                 out_last;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int idle_pct = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int settings_applied = 0;

  obstacle_table_tracker tracker = new();

  sphere_obstacle_table_core dut (.*);

  always #1 clk = ~clk;

  // Receiver: random stall with a bounded run length.
  always @(posedge clk) begin
    if (stall_run >= MAX_RUN || $urandom_range(0, 99) >= stall_pct) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else begin
      out_stall <= 1'b1;
      stall_run <= stall_run + 1;
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    sphere_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got.status = out_status;
      got.x      = out_hit_x;
      got.y      = out_hit_y;
      got.z      = out_hit_z;
      got.radius = out_hit_radius;
      got.last   = out_last;
      tracker.check_result(got);
    end
  end

  function automatic int unsigned rand_mag(input int w);
    int k;
    k = $urandom_range(0, w);
    return $urandom & ((32'd1 << k) - 1);
  endfunction

  function automatic int rand_signed(input int w);
    int m;
    m = rand_mag(w);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic sphere_request_t make_request(input logic kind, input int x,
                                                   input int y, input int z,
                                                   input int ext);
    sphere_request_t rq;
    rq.req_type = kind;
    rq.x = CW'(x);
    rq.y = CW'(y);
    rq.z = CW'(z);
    rq.ext = RAD_W'(ext);
    return rq;
  endfunction

  // Mostly requests aimed at stored spheres (near copies for inserts, nearby
  // positions for queries), the rest spread over the whole field range or kept near the origin.
  function automatic sphere_request_t make_random_request(input int insert_share);
    sphere_request_t rq;
    int pick;
    int w;
    rq.req_type = ($urandom_range(0, 99) < insert_share) ? REQ_INSERT : REQ_QUERY;
    if (tracker.count > 0 && $urandom_range(0, 99) < 70) begin
      pick = $urandom_range(0, tracker.count - 1);
      w = (rq.req_type == REQ_INSERT) ? 10 : 19;
      if (rq.req_type == REQ_INSERT && $urandom_range(0, 3) == 0) begin
        rq.x = tracker.cx[pick];
        rq.y = tracker.cy[pick];
        rq.z = tracker.cz[pick];
        rq.ext = tracker.r[pick];
      end else begin
        rq.x = tracker.cx[pick] + CW'(rand_signed(w));
        rq.y = tracker.cy[pick] + CW'(rand_signed(w));
        rq.z = tracker.cz[pick] + CW'(rand_signed(w));
        rq.ext = (rq.req_type == REQ_INSERT) ? tracker.r[pick] + RAD_W'(rand_signed(8))
                                             : RAD_W'(rand_mag(RAD_W));
      end
    end else begin
      if ($urandom_range(0, 1)) begin
        rq.x = CW'($urandom);
        rq.y = CW'($urandom);
        rq.z = CW'($urandom);
      end else begin
        rq.x = CW'(rand_signed(12));
        rq.y = CW'(rand_signed(12));
        rq.z = CW'(rand_signed(12));
      end
      rq.ext = RAD_W'(rand_mag(RAD_W));
    end
    return rq;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input sphere_request_t rq);
    in_valid    <= 1'b1;
    in_req_type <= rq.req_type;
    in_pos_x    <= rq.x;
    in_pos_y    <= rq.y;
    in_pos_z    <= rq.z;
    in_extent   <= rq.ext;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_request(rq);
  endtask

  task automatic idle_gap();
    int n = 0;
    while (n < MAX_RUN && $urandom_range(0, 99) < idle_pct) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off new requests until every predicted result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // One bus transfer; psel stays high so transfers can follow back to back.
  task automatic bus_transfer(input logic wr, input logic reg_sel,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({reg_sel, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic verify_register(input logic reg_sel);
    logic [DATA_W-1:0] data;
    bus_transfer(1'b0, reg_sel, '0, data);
    if (data !== tracker.tol_value(reg_sel))
      if (tracker.count_failure())
        $display("register %0d readback: expected %0h, actual %0h",
                 reg_sel, tracker.tol_value(reg_sel), data);
  endtask

  // Write both tolerances with junk above the register width, read each back.
  task automatic apply_tolerances(input logic [TOL_W-1:0] ctol, input logic [RAD_W-1:0] rtol);
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] unused;
    data = ($urandom & ~32'h0000_FFFF) | DATA_W'(ctol);
    bus_transfer(1'b1, REG_CENTER_TOL, data, unused);
    tracker.set_tol(REG_CENTER_TOL, data);
    verify_register(REG_CENTER_TOL);
    data = ($urandom & ~32'h0007_FFFF) | DATA_W'(rtol);
    bus_transfer(1'b1, REG_RADIUS_TOL, data, unused);
    tracker.set_tol(REG_RADIUS_TOL, data);
    verify_register(REG_RADIUS_TOL);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both tolerances come out of reset at one.
    verify_register(REG_CENTER_TOL);
    verify_register(REG_RADIUS_TOL);
    psel    <= 1'b0;
    penable <= 1'b0;

    // Empty table, centers at the origin, radius tolerance boundary, extremes.
    send_request(make_request(REQ_QUERY, 0, 0, 0, 0));
    send_request(make_request(REQ_INSERT, 0, 0, 0, 256));
    send_request(make_request(REQ_INSERT, 0, 0, 0, 256));
    send_request(make_request(REQ_INSERT, 0, 0, 0, 257));
    send_request(make_request(REQ_INSERT, CMAX, CMAX, CMAX, RMAX));
    send_request(make_request(REQ_INSERT, CMIN, CMIN, CMIN, 0));
    send_request(make_request(REQ_INSERT, CMAX, CMIN, 0, 1));
    send_request(make_request(REQ_INSERT, -1, -1, -1, 262144));
    send_request(make_request(REQ_INSERT, 256, 0, 0, 256));
    send_request(make_request(REQ_QUERY, 0, 0, 0, RMAX));
    send_request(make_request(REQ_QUERY, CMAX, CMAX, CMAX, 0));
    send_request(make_request(REQ_QUERY, CMIN, CMAX, CMIN, 0));
    send_request(make_request(REQ_QUERY, 256, 0, 0, 0));
    drain();

    // Widest tolerances: near copies are dropped as duplicates.
    apply_tolerances(16'hFFFF, 19'h7FFFF);
    send_request(make_request(REQ_INSERT, 257, 1, 0, 261));
    send_request(make_request(REQ_INSERT, CMAX, CMAX, CMAX, 1));
    send_request(make_request(REQ_QUERY, CMIN, CMIN, CMIN, RMAX));
    drain();

    // Zero tolerances: even an exact copy is stored again.
    apply_tolerances('0, '0);
    send_request(make_request(REQ_INSERT, 0, 0, 0, 256));
    send_request(make_request(REQ_QUERY, 0, 0, 0, 0));
    drain();

    // Random phases: free running, idle sender, stalling receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          apply_tolerances('0, '0);
        end
        1: begin
          idle_pct = 82;
          stall_pct = 0;
          apply_tolerances(16'hFFFF, 19'h7FFFF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 82;
          apply_tolerances(TOL_W'($urandom_range(1, 65535)), RAD_W'(rand_mag(RAD_W)));
        end
        default: begin
          idle_pct = 34;
          stall_pct = 34;
          apply_tolerances(TOL_W'(1), RAD_W'(1));
        end
      endcase
      for (int k = 0; k < PHASE_REQS; k++) begin
        send_request(make_random_request((ph == 0) ? 60 : 40));
        idle_gap();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d inserts and %0d queries under %0d tolerance settings,",
             tracker.inserts, tracker.queries, settings_applied);
    $display("%0d results compared.", tracker.checked);
    $display("Outcomes: inserted %0d, duplicate %0d, table full %0d, hit %0d, no hit %0d.",
             tracker.status_count[ST_INSERTED], tracker.status_count[ST_DUP],
             tracker.status_count[ST_FULL], tracker.status_count[ST_HIT],
             tracker.status_count[ST_NOHIT]);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
